/* design/cpc_pkg.sv */
// shared types and constants for the circulation pump controller
package cpc_pkg;

   localparam int COUNT_W             = 8;
   localparam int VALVE_COUNT_MAX_DEF = 255;
   localparam int SPEED_W             = 2;
   localparam int CSR_INDEX_W         = 2;
   localparam int CSR_DATA_W          = 8;

   // reciprocal of three, scaled by 2^9, exact for 8-bit values
   localparam logic [8:0] RECIP3_MUL   = 9'd171;
   localparam int         RECIP3_SHIFT = 9;

   typedef enum logic [2:0] {
      REQ_VALVE_OPEN    = 3'd0,
      REQ_VALVE_CLOSE   = 3'd1,
      REQ_MANUAL_TOGGLE = 3'd2,
      REQ_TRIGGER       = 3'd3,
      REQ_MANUAL_TMO    = 3'd4,
      REQ_STANDALONE    = 3'd5
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OFF      = 2'd0,
      ST_ON       = 2'd1,
      ST_MANUAL   = 2'd2,
      ST_DISABLED = 2'd3
   } pump_status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PUMP_CHANNEL = 2'd0,
      CSR_MAX_SPEED    = 2'd1,
      CSR_TOTAL_VALVES = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic       flag;
   } cpc_req_type;

   typedef struct packed {
      logic               pump_on;
      logic [SPEED_W-1:0] speed;
      logic [1:0]         pump_status;
      logic [COUNT_W-1:0] open_valves;
      logic               status_event;
      logic               timer_start;
   } cpc_rsp_type;

endpackage

/* design/circulation_pump_controller.sv */
// circulation pump controller: event-driven pump state, valve count and speed step
// request path: the request is registered, then its response is registered once the response register is free
// throughput: one request per cycle unless the response is stalled; state is updated in the single compute stage
// the next request sees the state left by the previous one without a bubble
// reset: synchronous active high; clears both stages, sets state and csr registers to defaults
module circulation_pump_controller
   import cpc_pkg::*;
#(
   parameter int VALVE_COUNT_MAX = VALVE_COUNT_MAX_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  cpc_req_type            req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output cpc_rsp_type            rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic [COUNT_W-1:0] CountMax = COUNT_W'(VALVE_COUNT_MAX);

   // csr registers
   logic               pump_channel_ff;
   logic [SPEED_W-1:0] max_speed_ff;
   logic [COUNT_W-1:0] total_valves_ff;

   // pipeline
   logic               req_valid_ff;
   cpc_req_type        req_data_ff;
   logic               rsp_valid_ff;
   cpc_rsp_type        rsp_data_ff;
   cpc_rsp_type        rsp_data_in;
   logic               advance;

   // controller state
   logic [COUNT_W-1:0] valve_count_ff, valve_count_in;
   logic               running_ff, running_in;
   logic               manual_ff, manual_in;
   logic               enabled_ff, enabled_in;
   pump_status_type    status_ff, status_in;
   logic [SPEED_W-1:0] speed_ff, speed_in;
   logic               ev_status, ev_timer;

   // speed thresholds
   logic [SPEED_W-1:0] eff_max;
   logic [16:0]        third_prod;
   logic [COUNT_W-1:0] third_thr;
   logic [COUNT_W-1:0] two_third_thr;
   logic [COUNT_W-1:0] half_thr;

   function automatic logic [SPEED_W-1:0] pick_speed(
      input logic [COUNT_W-1:0] cnt,
      input logic [COUNT_W-1:0] total,
      input logic [SPEED_W-1:0] mx,
      input logic [COUNT_W-1:0] half,
      input logic [COUNT_W-1:0] third,
      input logic [COUNT_W-1:0] two_third
   );
      logic [SPEED_W-1:0] spd;
      spd = 2'd1;
      if (total == '0 || mx == 2'd1) begin
         spd = 2'd1;
      end else if (mx == 2'd2) begin
         spd = (cnt <= half) ? 2'd1 : 2'd2;
      end else begin
         if (cnt <= third) spd = 2'd1;
         else if (cnt <= two_third) spd = 2'd2;
         else spd = 2'd3;
      end
      return spd;
   endfunction

   assign eff_max       = (max_speed_ff == '0) ? 2'd1 : max_speed_ff;
   assign third_prod    = total_valves_ff * RECIP3_MUL;
   assign third_thr     = COUNT_W'(third_prod >> RECIP3_SHIFT);
   assign two_third_thr = {third_thr[COUNT_W-2:0], 1'b0};
   assign half_thr      = total_valves_ff >> 1;

   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      valve_count_in = valve_count_ff;
      running_in     = running_ff;
      manual_in      = manual_ff;
      enabled_in     = enabled_ff;
      status_in      = status_ff;
      speed_in       = speed_ff;
      ev_status      = 1'b0;
      ev_timer       = 1'b0;

      case (req_kind_type'(req_data_ff.req_type))
         REQ_VALVE_OPEN: begin
            if (valve_count_in < CountMax) valve_count_in = valve_count_in + 1'b1;
            speed_in = pick_speed(valve_count_in, total_valves_ff, eff_max,
                                  half_thr, third_thr, two_third_thr);
            if (!manual_in && !running_in && pump_channel_ff && enabled_in) begin
               running_in = 1'b1;
               status_in  = ST_ON;
               ev_status  = 1'b1;
            end
         end
         REQ_VALVE_CLOSE: begin
            if (valve_count_in != '0) valve_count_in = valve_count_in - 1'b1;
            speed_in = pick_speed(valve_count_in, total_valves_ff, eff_max,
                                  half_thr, third_thr, two_third_thr);
            if (valve_count_in == '0 && !manual_in && running_in && pump_channel_ff) begin
               running_in = 1'b0;
               if (status_in != ST_DISABLED) begin
                  status_in = ST_OFF;
                  ev_status = 1'b1;
               end
            end
         end
         REQ_MANUAL_TOGGLE, REQ_MANUAL_TMO: begin
            if (req_data_ff.req_type == REQ_MANUAL_TOGGLE || manual_in) begin
               manual_in = !manual_in;
               if (pump_channel_ff) begin
                  if (manual_in) begin
                     running_in = 1'b1;
                     ev_timer   = 1'b1;
                     status_in  = ST_MANUAL;
                     ev_status  = 1'b1;
                  end else if (valve_count_in == '0) begin
                     running_in = 1'b0;
                     if (status_in != ST_DISABLED) begin
                        status_in = ST_OFF;
                        ev_status = 1'b1;
                     end
                  end else if (enabled_in) begin
                     running_in = 1'b1;
                     status_in  = ST_ON;
                     ev_status  = 1'b1;
                  end else begin
                     running_in = 1'b0;
                     if (status_in != ST_DISABLED) begin
                        status_in = ST_DISABLED;
                        ev_status = 1'b1;
                     end
                  end
               end
            end
         end
         REQ_TRIGGER: begin
            enabled_in = req_data_ff.flag;
            if (status_in != ST_MANUAL) begin
               if (!req_data_ff.flag) begin
                  if (status_in != ST_DISABLED) begin
                     status_in = ST_DISABLED;
                     ev_status = 1'b1;
                     if (pump_channel_ff && running_in && !manual_in) running_in = 1'b0;
                  end
               end else if (status_in == ST_DISABLED || status_in == ST_OFF) begin
                  if (valve_count_in != '0) begin
                     if (pump_channel_ff && !running_in) begin
                        running_in = 1'b1;
                        if (!manual_in) begin
                           status_in = ST_ON;
                           ev_status = 1'b1;
                        end
                     end
                  end else begin
                     status_in = ST_OFF;
                     ev_status = 1'b1;
                  end
               end
            end
         end
         REQ_STANDALONE: begin
            if (req_data_ff.flag) begin
               if (valve_count_in < CountMax) valve_count_in = valve_count_in + 1'b1;
            end else if (valve_count_in != '0) begin
               valve_count_in = valve_count_in - 1'b1;
            end
         end
         default: begin
         end
      endcase

      rsp_data_in.pump_on      = running_in && pump_channel_ff;
      rsp_data_in.speed        = speed_in;
      rsp_data_in.pump_status  = status_in;
      rsp_data_in.open_valves  = valve_count_in;
      rsp_data_in.status_event = ev_status;
      rsp_data_in.timer_start  = ev_timer;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pump_channel_ff <= 1'b0;
         max_speed_ff    <= 2'd1;
         total_valves_ff <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PUMP_CHANNEL: pump_channel_ff <= csr_wdata[0];
            CSR_MAX_SPEED:    max_speed_ff    <= csr_wdata[SPEED_W-1:0];
            CSR_TOTAL_VALVES: total_valves_ff <= csr_wdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         valve_count_ff <= '0;
         running_ff     <= 1'b0;
         manual_ff      <= 1'b0;
         enabled_ff     <= 1'b1;
         status_ff      <= ST_OFF;
         speed_ff       <= 2'd1;
      end else begin
         if (req_ready) req_valid_ff <= req_valid;
         if (advance) begin
            rsp_valid_ff   <= 1'b1;
            valve_count_ff <= valve_count_in;
            running_ff     <= running_in;
            manual_ff      <= manual_in;
            enabled_ff     <= enabled_in;
            status_ff      <= status_in;
            speed_ff       <= speed_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_data_ff <= req_data;
      if (advance) rsp_data_ff <= rsp_data_in;
   end

   // speed step stays within 1..3
   a_speed_nonzero: assert property (@(posedge clock) disable iff (reset)
      speed_ff != '0)
      else $error("speed step is zero");

   // valve count never passes its limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      valve_count_ff <= CountMax)
      else $error("valve count above limit");

   // timer start only together with a change to manual status
   a_timer_manual: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.timer_start |->
         rsp_data_ff.status_event && rsp_data_ff.pump_status == ST_MANUAL)
      else $error("timer start without manual status event");

   // a request that advances from the compute stage yields a response next cycle
   a_advance_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("response missing after request advance");

endmodule
